// ===== src/neighbor_median_filtered_top_assert.svh =====
// Assertion macros for the neighbor median filter
`ifndef NEIGHBOR_MEDIAN_FILTERED_TOP_ASSERT_SVH
`define NEIGHBOR_MEDIAN_FILTERED_TOP_ASSERT_SVH

// Check an implication on every clock edge outside reset
`define NMF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle
`define NMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/nmf_pkg.sv =====
// Package: constants, types and register codes for the neighbor median filter
`default_nettype none
package nmf_pkg;
    localparam int MAX_NEIGHBORS_DEF = 64;
    localparam int VALUE_BITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int INDEX_BITS        = 21;
    localparam int PADDR_BITS        = 2;
    localparam logic [INDEX_BITS-1:0] CELL_COUNT_RESET = 21'd1048576;
    localparam logic [PADDR_BITS-1:0] REG_CELL_COUNT   = 2'd0;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_MID,
        ST_RESULT
    } t_back_state;
endpackage
`default_nettype wire

// ===== src/nmf_if.sv =====
// Valid/ready channel interface
`default_nettype none
interface nmf_if #(
    parameter int W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/nmf_front.sv =====
// Front: accept neighbor beats, qualify them and queue {keep, last, value}
`default_nettype none
module nmf_front
    import nmf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [INDEX_BITS-1:0] i_cell_count,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [INDEX_BITS-1:0] i_index,
    input  wire logic                  i_present,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic                  i_finite,
    input  wire logic                  i_last,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [VALUE_BITS+1:0]      o_data
);
    localparam int DEPTH = 4;
    logic [VALUE_BITS+1:0] r_q [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       keep, push, pop;

    assign keep    = i_present && i_finite && (i_index != '0) && (i_index <= i_cell_count);
    assign o_ready = (r_cnt != 3'(DEPTH));
    assign push    = i_valid && o_ready;
    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= {keep, i_last, i_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== src/nmf_back.sv =====
// Back: insertion-sorted cell chain and median readout
`default_nettype none
module nmf_back
    import nmf_pkg::*;
#(
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
    parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [VALUE_BITS+1:0] i_data,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [VALUE_BITS-1:0]      o_median,
    output logic                       o_empty,
    output logic                       o_overflow
);
    localparam int CW = $clog2(MAX_NEIGHBORS + 1);
    localparam int AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

    t_back_state r_state, n_state;
    logic signed [VALUE_BITS-1:0] r_cell [MAX_NEIGHBORS];
    logic [CW-1:0] r_cnt;
    logic          r_ovf;
    logic signed [VALUE_BITS-1:0] r_a, r_b;
    logic          r_odd;
    logic [VALUE_BITS-1:0] r_med;
    logic          r_empty, r_ovf_out, r_oval;
    logic          take, keep, last, full;
    logic signed [VALUE_BITS-1:0] v;
    logic [CW-1:0] cnt_n;
    logic [AW-1:0] mid_hi, mid_lo;
    logic signed [VALUE_BITS:0] sum;

    assign keep = i_data[VALUE_BITS+1];
    assign last = i_data[VALUE_BITS];
    assign v    = i_data[VALUE_BITS-1:0];
    assign full = (r_cnt == CW'(MAX_NEIGHBORS));
    assign o_ready = (r_state == ST_COLLECT);
    assign take = i_valid && o_ready;
    assign cnt_n = r_cnt - CW'(1);
    assign mid_hi = AW'(r_cnt >> 1);
    assign mid_lo = AW'(cnt_n >> 1);
    assign sum = {r_a[VALUE_BITS-1], r_a} + {r_b[VALUE_BITS-1], r_b};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_COLLECT: if (take && last) n_state = ST_MID;
            ST_MID:     n_state = ST_RESULT;
            ST_RESULT:  if (!r_oval || i_ready) n_state = ST_COLLECT;
            default:    n_state = ST_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take && keep && !full) begin
            for (int k = 0; k < MAX_NEIGHBORS; k++) begin
                if (CW'(k) <= r_cnt) begin
                    if (k == 0) begin
                        if (r_cnt == '0 || r_cell[0] > v) r_cell[0] <= v;
                        else if (CW'(k) == r_cnt) r_cell[k] <= v;
                    end else if (CW'(k) == r_cnt) begin
                        r_cell[k] <= (r_cell[k-1] > v) ? r_cell[k-1] : v;
                    end else if (r_cell[k-1] > v) begin
                        r_cell[k] <= r_cell[k-1];
                    end else if (r_cell[k] > v) begin
                        r_cell[k] <= v;
                    end
                end
            end
        end
        if (r_state == ST_MID) begin
            r_a   <= r_cell[mid_lo];
            r_b   <= r_cell[mid_hi];
            r_odd <= r_cnt[0];
        end
        if (r_state == ST_RESULT && (!r_oval || i_ready)) begin
            r_med     <= (r_cnt == '0) ? '0 :
                         (r_odd ? r_a : sum[VALUE_BITS:1]);
            r_empty   <= (r_cnt == '0);
            r_ovf_out <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take && keep) begin
                if (full) r_ovf <= 1'b1;
                else      r_cnt <= r_cnt + CW'(1);
            end
            if (r_state == ST_RESULT && (!r_oval || i_ready)) begin
                r_oval <= 1'b1;
                r_cnt  <= '0;
                r_ovf  <= 1'b0;
            end else if (r_oval && i_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    assign o_valid    = r_oval;
    assign o_median   = r_med;
    assign o_empty    = r_empty;
    assign o_overflow = r_ovf_out;

`include "neighbor_median_filtered_top_assert.svh"
    `NMF_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_NEIGHBORS), "count over capacity")
    `NMF_ASSERT_IMP(a_ovf_full, i_clk, i_rst_n, r_ovf && r_state == ST_COLLECT, full, "overflow without full store")
    `NMF_ASSERT_NEXT(a_last_mid, i_clk, i_rst_n, take && last, r_state == ST_MID, "last beat not closed")
    `NMF_ASSERT_NEXT(a_res_out, i_clk, i_rst_n, r_state == ST_RESULT && (!r_oval || i_ready), r_oval && r_cnt == '0, "result not posted")
endmodule
`default_nettype wire

// ===== src/neighbor_median_filtered_top.sv =====
// Top level: APB register, qualifying front, queue and sorting back end
//
// Input channel carries one neighbor beat per cycle while ready is high:
// index, presence flag, Q16.16 coordinate, finiteness flag and a
// last-of-group mark. A beat is kept when present, finite and its index
// lies in 1..cell_count. Kept values enter a sorted cell chain of
// MAX_NEIGHBORS entries, one per cycle while the back end collects.
// Throughput: one beat per cycle within a group while the queue has room;
// after a group's last beat the back end takes none while it reads the
// middle cells (ST_MID), then writes the median or mean into the output
// register (ST_RESULT), while the four-entry queue keeps input flowing.
// Path of a last beat: queue, ST_MID, ST_RESULT, then the output register.
// Output channel: median, empty flag, overflow flag. When the receiver
// stalls the result is held and the back end, then the queue, then the
// input stall in turn.
// Reset (synchronous, active low) empties queue and chain, drops any
// pending result and sets cell_count to 1048576.
// cell_count is written over APB at address 0; write it only while idle.
`default_nettype none
module neighbor_median_filtered_top
    import nmf_pkg::*;
#(
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
    parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    nmf_if.sink                        i_nbr,
    nmf_if.source                      o_med
);
    logic [INDEX_BITS-1:0] r_cell_count;
    logic                  q_valid, q_ready;
    logic [VALUE_BITS+1:0] q_data;
    logic [VALUE_BITS-1:0] med;
    logic                  empty, ovf;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_CELL_COUNT) ? {11'd0, r_cell_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count <= CELL_COUNT_RESET;
        end else if (psel && penable && pwrite && paddr == REG_CELL_COUNT) begin
            r_cell_count <= pwdata[INDEX_BITS-1:0];
        end
    end

    nmf_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_cell_count (r_cell_count),
        .i_valid      (i_nbr.valid),
        .o_ready      (i_nbr.ready),
        .i_index      (i_nbr.data[INDEX_BITS+VALUE_BITS+2:VALUE_BITS+3]),
        .i_present    (i_nbr.data[VALUE_BITS+2]),
        .i_value      (i_nbr.data[VALUE_BITS+1:2]),
        .i_finite     (i_nbr.data[1]),
        .i_last       (i_nbr.data[0]),
        .o_valid      (q_valid),
        .i_ready      (q_ready),
        .o_data       (q_data)
    );

    nmf_back #(.MAX_NEIGHBORS(MAX_NEIGHBORS), .VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid    (q_valid),
        .o_ready    (q_ready),
        .i_data     (q_data),
        .o_valid    (o_med.valid),
        .i_ready    (o_med.ready),
        .o_median   (med),
        .o_empty    (empty),
        .o_overflow (ovf)
    );

    assign o_med.data = {med, empty, ovf};
endmodule
`default_nettype wire

// ===== verif/nmf_tb_pkg.sv =====
// Beat layouts shared by the neighbor median filter testbench modules
package nmf_tb_pkg;
    import nmf_pkg::*;

    typedef struct packed {
        logic [INDEX_BITS-1:0] neighbor_index;
        logic                  index_present;
        logic signed [31:0]    coordinate;
        logic                  coordinate_finite;
        logic                  last_in_group;
    } t_nbr_beat;

    typedef struct packed {
        logic signed [31:0] median_value;
        logic               group_empty;
        logic               store_overflow;
    } t_med_beat;
endpackage

// ===== verif/nmf_median_checker.sv =====
// Checker: tracks the neighbor median filter's beats and compares its medians, empty and overflow flags
module nmf_median_checker
    import nmf_pkg::*;
    import nmf_tb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic                  nbr_valid,
    input  logic                  nbr_ready,
    input  t_nbr_beat             nbr_data,
    input  logic                  med_valid,
    input  logic                  med_ready,
    input  t_med_beat             med_data,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [31:0]    sorted_coords [MAX_NEIGHBORS_DEF];
    int                    kept;
    logic                  dropped;
    logic [INDEX_BITS-1:0] cells;
    t_med_beat             medians_due [$];

    assign o_pending = medians_due.size();

    task automatic take_neighbor(input t_nbr_beat b);
        int        pos;
        t_med_beat m;
        logic signed [32:0] pair_sum;
        if (b.index_present && b.coordinate_finite && b.neighbor_index >= 1 &&
            b.neighbor_index <= cells) begin
            if (kept < MAX_NEIGHBORS_DEF) begin
                pos = kept;
                while (pos > 0 && sorted_coords[pos-1] > b.coordinate) begin
                    sorted_coords[pos] = sorted_coords[pos-1];
                    pos--;
                end
                sorted_coords[pos] = b.coordinate;
                kept++;
            end else begin
                dropped = 1'b1;
            end
        end
        if (b.last_in_group) begin
            m.median_value = '0;
            if (kept % 2 == 1) begin
                m.median_value = sorted_coords[kept/2];
            end else if (kept > 0) begin
                pair_sum = 33'(sorted_coords[kept/2-1]) + 33'(sorted_coords[kept/2]);
                m.median_value = 32'(pair_sum >>> 1);
            end
            m.group_empty = (kept == 0);
            m.store_overflow = dropped;
            medians_due = {medians_due, m};
            kept = 0;
            dropped = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_med_beat want;
        if (!i_rst_n) begin
            o_errors = 0;
            cells = CELL_COUNT_RESET;
            kept = 0;
            dropped = 1'b0;
            medians_due.delete();
        end else begin
            if (psel && penable && pwrite && paddr == REG_CELL_COUNT)
                cells = pwdata[INDEX_BITS-1:0];
            if (nbr_valid && nbr_ready)
                take_neighbor(nbr_data);
            if (med_valid && med_ready) begin
                if (medians_due.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected median beat %h", $realtime, med_data);
                end else begin
                    want = medians_due.pop_front();
                    if (want.median_value !== med_data.median_value) begin
                        o_errors++;
                        $display("%0t: median_value expected %h actual %h", $realtime,
                                 want.median_value, med_data.median_value);
                    end
                    if (want.group_empty !== med_data.group_empty) begin
                        o_errors++;
                        $display("%0t: group_empty expected %b actual %b", $realtime,
                                 want.group_empty, med_data.group_empty);
                    end
                    if (want.store_overflow !== med_data.store_overflow) begin
                        o_errors++;
                        $display("%0t: store_overflow expected %b actual %b", $realtime,
                                 want.store_overflow, med_data.store_overflow);
                    end
                end
            end
        end
    end
endmodule

// ===== verif/neighbor_median_filtered_top_tb.sv =====
// Testbench top: drives neighbor groups, cell_count writes and receiver stalls, gives the verdict
module neighbor_median_filtered_top_tb;
    import nmf_pkg::*;
    import nmf_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    int                    errors;
    int                    pending;
    int                    send_idle;
    int                    recv_idle;
    int                    hold_cycles;
    int                    sent;
    logic [INDEX_BITS-1:0] cells;

    nmf_if #(.W($bits(t_nbr_beat))) nbr ();
    nmf_if #(.W($bits(t_med_beat))) med ();

    neighbor_median_filtered_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_nbr   (nbr.sink),
        .o_med   (med.source)
    );

    nmf_median_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .nbr_valid (nbr.valid),
        .nbr_ready (nbr.ready),
        .nbr_data  (t_nbr_beat'(nbr.data)),
        .med_valid (med.valid),
        .med_ready (med.ready),
        .med_data  (t_med_beat'(med.data)),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            med.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            med.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_neighbor(input logic [INDEX_BITS-1:0] idx, input logic present,
                                 input logic [31:0] coord, input logic finite,
                                 input logic last);
        t_nbr_beat b;
        b = '{idx, present, coord, finite, last};
        while ($urandom_range(99) < send_idle) begin
            @(negedge i_clk);
            nbr.valid <= 1'b0;
        end
        @(negedge i_clk);
        nbr.valid <= 1'b1;
        nbr.data <= b;
        @(posedge i_clk);
        while (!nbr.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic write_cells(input logic [INDEX_BITS-1:0] value);
        @(negedge i_clk);
        nbr.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= REG_CELL_COUNT;
        pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cells = value;
    endtask

    task automatic send_random_group(input int size);
        logic [INDEX_BITS-1:0] idx;
        logic [31:0]           coord;
        int                    k;
        for (int n = 0; n < size; n++) begin
            k = $urandom_range(99);
            if (cells == 0 || k < 8)
                idx = INDEX_BITS'($urandom);
            else if (k < 12)
                idx = '0;
            else if (k < 16)
                idx = (cells == 21'h1FFFFF) ? cells : cells + 21'd1;
            else if (k < 20)
                idx = cells;
            else
                idx = INDEX_BITS'($urandom_range(1, cells));
            k = $urandom_range(99);
            if (k < 6)
                coord = 32'h7FFFFFFF;
            else if (k < 12)
                coord = 32'h80000000;
            else if (k < 30)
                coord = $urandom_range(0, 7) - 4;
            else
                coord = $urandom;
            send_neighbor(idx, $urandom_range(99) < 92, coord, $urandom_range(99) < 92,
                          n == size - 1);
        end
    endtask

    initial begin
        logic [INDEX_BITS-1:0] settings [6];
        settings = '{21'd1048576, 21'd1, 21'h1FFFFF, 21'd0, 21'd37, 21'd1};
        settings[5] = INDEX_BITS'($urandom_range(1, 1048576));
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        nbr.valid = 1'b0;
        nbr.data = '0;
        med.ready = 1'b0;
        hold_cycles = 0;
        send_idle = 38;
        recv_idle = 72;
        sent = 0;
        cells = CELL_COUNT_RESET;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_neighbor(21'd1, 1'b1, 32'h7FFFFFFF, 1'b1, 1'b0);
        send_neighbor(21'd1048576, 1'b1, 32'h7FFFFFFF, 1'b1, 1'b1);
        send_neighbor(21'd5, 1'b1, 32'h80000000, 1'b1, 1'b0);
        send_neighbor(21'd6, 1'b1, 32'h80000000, 1'b1, 1'b1);
        send_neighbor(21'd7, 1'b1, 32'hFFFFFFFF, 1'b1, 1'b0);
        send_neighbor(21'd8, 1'b1, 32'h00000000, 1'b1, 1'b1);
        send_neighbor(21'd0, 1'b1, 32'h5, 1'b1, 1'b0);
        send_neighbor(21'd1048577, 1'b1, 32'h6, 1'b1, 1'b0);
        send_neighbor(21'd9, 1'b0, 32'h7, 1'b1, 1'b0);
        send_neighbor(21'd10, 1'b1, 32'h8, 1'b0, 1'b1);
        send_neighbor(21'h1FFFFF, 1'b1, 32'h9, 1'b1, 1'b1);
        send_neighbor(21'd3, 1'b1, 32'h80000000, 1'b1, 1'b0);
        send_neighbor(21'd4, 1'b1, 32'h7FFFFFFF, 1'b1, 1'b0);
        send_neighbor(21'd5, 1'b1, 32'h00010000, 1'b1, 1'b1);
        send_neighbor(21'd11, 1'b1, 32'h7FFFFFFF, 1'b1, 1'b0);
        send_neighbor(21'd12, 1'b1, 32'h80000000, 1'b1, 1'b1);
        send_neighbor(21'd13, 1'b1, 32'h00018000, 1'b0, 1'b0);
        send_neighbor(21'd14, 1'b1, 32'hFFFE8000, 1'b1, 1'b1);

        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) write_cells(settings[phase]);
            send_idle = (phase < 2) ? 38 : (phase < 4) ? 72 : 0;
            recv_idle = (phase < 2) ? 72 : (phase < 4) ? 38 : 0;
            if (phase == 0 || phase == 4) hold_cycles = 400;
            send_random_group(68);
            while (sent < 18 + 90 * (phase + 1))
                send_random_group(($urandom_range(39) == 0) ? $urandom_range(64, 70)
                                                             : $urandom_range(1, 12));
        end

        @(negedge i_clk);
        nbr.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== neighbor_median_filtered_top.f =====
+incdir+src
src/nmf_pkg.sv
src/nmf_if.sv
src/nmf_front.sv
src/nmf_back.sv
src/neighbor_median_filtered_top.sv
verif/nmf_tb_pkg.sv
verif/nmf_median_checker.sv
verif/neighbor_median_filtered_top_tb.sv
